>>> rtl/file_read_block_mapper_top_macros.svh
// ----------------------------------------------------------------------------
// file_read_block_mapper_top_macros
// Assertion macros used by the mapper controller.
// ----------------------------------------------------------------------------
`ifndef FILE_READ_BLOCK_MAPPER_TOP_MACROS_SVH
`define FILE_READ_BLOCK_MAPPER_TOP_MACROS_SVH

// check on every clock edge outside reset
`define FRBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check on every clock edge, reset included
`define FRBM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/frbm_pkg.sv
// ----------------------------------------------------------------------------
// frbm_pkg
// Types and constants of the file read block mapper.
// ----------------------------------------------------------------------------
package frbm_pkg;

    localparam int unsigned BASE_LOG = 10;
    localparam logic [2:0]  MAX_LOG  = 3'd6;
    localparam logic [48:0] DISK_LIMIT = 49'h1_0000_0000_0000;

    localparam logic [1:0] CFG_MOUNTED  = 2'd0;
    localparam logic [1:0] CFG_LOG_SIZE = 2'd1;
    localparam logic [1:0] CFG_DISK     = 2'd2;

    localparam logic [3:0] MODE_REGULAR = 4'h8;

    typedef enum logic [2:0] {
        ST_CHUNK       = 3'd0,
        ST_DONE        = 3'd1,
        ST_NOT_MOUNTED = 3'd2,
        ST_NOT_REGULAR = 3'd3,
        ST_IO_ERROR    = 3'd4
    } status_t;

    typedef struct packed {
        logic    load_ptr;
        logic    start;
        logic    clamp;
        logic    emit;
        status_t code;
    } frbm_cmd_t;

    typedef struct packed {
        status_t check_code;
        logic    walk_end;
        logic    walk_io;
    } frbm_stat_t;

endpackage

>>> rtl/frbm_in_if.sv
// ----------------------------------------------------------------------------
// frbm_in_if
// Input channel: load and read words.
// ----------------------------------------------------------------------------
interface frbm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  slot;
    logic [31:0] block_number;
    logic [31:0] file_bytes;
    logic [15:0] file_mode;
    logic [31:0] read_offset;
    logic [31:0] read_count;

    modport source (
        output valid, kind, slot, block_number, file_bytes, file_mode,
               read_offset, read_count,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, block_number, file_bytes, file_mode,
               read_offset, read_count,
        output ready
    );
endinterface

>>> rtl/frbm_out_if.sv
// ----------------------------------------------------------------------------
// frbm_out_if
// Output channel: chunk and completion words.
// ----------------------------------------------------------------------------
interface frbm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [47:0] disk_address;
    logic [16:0] length;
    logic        zero_fill;
    logic [31:0] dest_offset;
    logic [31:0] total_bytes;
    logic        last;

    modport source (
        output valid, status, disk_address, length, zero_fill, dest_offset,
               total_bytes, last,
        input  ready
    );
    modport sink (
        input  valid, status, disk_address, length, zero_fill, dest_offset,
               total_bytes, last,
        output ready
    );
endinterface

>>> rtl/frbm_dp.sv
// ----------------------------------------------------------------------------
// frbm_dp
// Datapath: config registers, block pointer table, walk registers, output word.
// ----------------------------------------------------------------------------
module frbm_dp
    import frbm_pkg::*;
#(
    parameter int DIRECT_SLOTS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [48:0] cfg_data,
    input  frbm_cmd_t   cmd,
    output frbm_stat_t  stat,
    input  logic [3:0]  slot,
    input  logic [31:0] block_number,
    input  logic [31:0] file_bytes,
    input  logic [15:0] file_mode,
    input  logic [31:0] read_offset,
    input  logic [31:0] read_count,
    output logic [2:0]  status,
    output logic [47:0] disk_address,
    output logic [16:0] length,
    output logic        zero_fill,
    output logic [31:0] dest_offset,
    output logic [31:0] total_bytes,
    output logic        last
);

    logic        mounted_reg;
    logic [2:0]  log_reg;
    logic [48:0] disk_reg;
    logic [31:0] ptr_reg [DIRECT_SLOTS];

    logic [31:0] fsize_reg;
    logic [3:0]  mode_reg;
    logic [31:0] pos_reg;
    logic [31:0] rem_reg;
    logic [31:0] done_reg;
    logic [2:0]  lg_reg;
    logic [38:0] limit_reg;

    logic [2:0]  status_reg;
    logic [47:0] addr_reg;
    logic [16:0] length_reg;
    logic        zero_reg;
    logic [31:0] dest_reg;
    logic [31:0] total_reg;
    logic        last_reg;

    logic [2:0]  lg_sat;
    logic [48:0] disk_sat;
    logic [4:0]  shift;
    logic [31:0] idx;
    logic [31:0] blk;
    logic [16:0] bs;
    logic [16:0] boff;
    logic [16:0] room;
    logic [16:0] chunk;
    logic [47:0] addr;
    logic [31:0] avail;

    assign lg_sat   = (log_reg > MAX_LOG) ? MAX_LOG : log_reg;
    assign disk_sat = (disk_reg > DISK_LIMIT) ? DISK_LIMIT : disk_reg;
    assign shift    = 5'(BASE_LOG) + {2'b00, lg_reg};
    assign idx      = pos_reg >> shift;
    assign bs       = 17'd1 << shift;
    assign boff     = pos_reg[16:0] & (bs - 17'd1);
    assign room     = bs - boff;
    assign chunk    = (rem_reg < {15'd0, room}) ? rem_reg[16:0] : room;
    assign addr     = ({16'd0, blk} << shift) | {31'd0, boff};
    assign avail    = fsize_reg - pos_reg;

    always_comb
    begin
        blk = '0;
        for (int i = 0; i < DIRECT_SLOTS; i++)
        begin
            if (idx[3:0] == 4'(i))
            begin
                blk = ptr_reg[i];
            end
        end
    end

    always_comb
    begin
        if (!mounted_reg)
        begin
            stat.check_code = ST_NOT_MOUNTED;
        end
        else if (mode_reg != MODE_REGULAR)
        begin
            stat.check_code = ST_NOT_REGULAR;
        end
        else if (pos_reg >= fsize_reg)
        begin
            stat.check_code = ST_DONE;
        end
        else
        begin
            stat.check_code = ST_CHUNK;
        end
        stat.walk_end = (rem_reg == '0) || (idx >= 32'(DIRECT_SLOTS));
        stat.walk_io  = (blk != '0) && ({7'd0, blk} >= limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mounted_reg <= 1'b0;
            log_reg     <= '0;
            disk_reg    <= '0;
            for (int i = 0; i < DIRECT_SLOTS; i++)
            begin
                ptr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MOUNTED:  mounted_reg <= cfg_data[0];
                    CFG_LOG_SIZE: log_reg     <= cfg_data[2:0];
                    CFG_DISK:     disk_reg    <= cfg_data;
                    default:      ;
                endcase
            end
            for (int i = 0; i < DIRECT_SLOTS; i++)
            begin
                if (cmd.load_ptr && slot == 4'(i))
                begin
                    ptr_reg[i] <= block_number;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            fsize_reg <= file_bytes;
            mode_reg  <= file_mode[15:12];
            pos_reg   <= read_offset;
            rem_reg   <= read_count;
            done_reg  <= '0;
            lg_reg    <= lg_sat;
            limit_reg <= 39'(disk_sat >> (5'(BASE_LOG) + {2'b00, lg_sat}));
        end
        else if (cmd.clamp)
        begin
            if (rem_reg > avail)
            begin
                rem_reg <= avail;
            end
        end
        else if (cmd.emit && cmd.code == ST_CHUNK)
        begin
            pos_reg  <= pos_reg + {15'd0, chunk};
            rem_reg  <= rem_reg - {15'd0, chunk};
            done_reg <= done_reg + {15'd0, chunk};
        end

        if (cmd.emit)
        begin
            status_reg <= 3'(cmd.code);
            if (cmd.code == ST_CHUNK)
            begin
                addr_reg   <= (blk == '0) ? '0 : addr;
                length_reg <= chunk;
                zero_reg   <= (blk == '0);
                dest_reg   <= done_reg;
                total_reg  <= done_reg + {15'd0, chunk};
                last_reg   <= 1'b0;
            end
            else
            begin
                addr_reg   <= '0;
                length_reg <= '0;
                zero_reg   <= 1'b0;
                dest_reg   <= '0;
                total_reg  <= done_reg;
                last_reg   <= 1'b1;
            end
        end
    end

    assign status       = status_reg;
    assign disk_address = addr_reg;
    assign length       = length_reg;
    assign zero_fill    = zero_reg;
    assign dest_offset  = dest_reg;
    assign total_bytes  = total_reg;
    assign last         = last_reg;

endmodule

>>> rtl/frbm_ctrl.sv
// ----------------------------------------------------------------------------
// frbm_ctrl
// Controller: accepts words, sequences check and walk, owns output valid.
// ----------------------------------------------------------------------------
`include "file_read_block_mapper_top_macros.svh"

module frbm_ctrl
    import frbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_kind,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  frbm_stat_t stat,
    output frbm_cmd_t  cmd
);

    typedef enum logic [1:0] {
        IDLE,
        CHECK,
        WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;
    logic   final_emit;

    assign in_ready   = (state_reg == IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign final_emit = cmd.emit && (cmd.code != ST_CHUNK);

    always_comb
    begin
        state_next   = state_reg;
        cmd.load_ptr = 1'b0;
        cmd.start    = 1'b0;
        cmd.clamp    = 1'b0;
        cmd.emit     = 1'b0;
        cmd.code     = ST_CHUNK;
        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (in_kind)
                    begin
                        cmd.start  = 1'b1;
                        state_next = CHECK;
                    end
                    else
                    begin
                        cmd.load_ptr = 1'b1;
                    end
                end
            end
            CHECK:
            begin
                if (stat.check_code == ST_CHUNK)
                begin
                    cmd.clamp  = 1'b1;
                    state_next = WALK;
                end
                else if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = stat.check_code;
                    state_next = IDLE;
                end
            end
            WALK:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    priority if (stat.walk_end)
                    begin
                        cmd.code   = ST_DONE;
                        state_next = IDLE;
                    end
                    else if (stat.walk_io)
                    begin
                        cmd.code   = ST_IO_ERROR;
                        state_next = IDLE;
                    end
                    else
                    begin
                        cmd.code = ST_CHUNK;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FRBM_ASSERT_RST(a_reset_no_word, !rst_n |=> !out_valid_reg, "word valid in reset")
    `FRBM_ASSERT(a_emit_free, cmd.emit |-> out_free, "emit overwrote word")
    `FRBM_ASSERT(a_read_check, (accept && in_kind) |=> (state_reg == CHECK), "check skipped")
    `FRBM_ASSERT(a_final_idle, final_emit |=> (in_ready && out_valid_reg), "final word lost")

endmodule

>>> rtl/file_read_block_mapper_top.sv
// ----------------------------------------------------------------------------
// file_read_block_mapper_top
// Maps a file read over direct block pointers into disk copy chunks.
//
//   channel   dir   handshake          words
//   item      in    valid/ready        load slot or read request
//   result    out   valid/ready        chunk, done or error
//   cfg       in    cfg_we             mounted, log block size, disk bytes
//
// A load word writes its pointer slot when accepted. A read is accepted,
// checked, then walked, emitting its chunk words and then its final word.
// A read rejected at the check emits its one word there.
// The walk emits through a single output register; a stalled result holds
// the walk in place. Reset clears config, the pointer table and control.
// ----------------------------------------------------------------------------
module file_read_block_mapper_top
    import frbm_pkg::*;
#(
    parameter int DIRECT_SLOTS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [48:0] cfg_data,
    frbm_in_if.sink     item,
    frbm_out_if.source  result
);

    frbm_cmd_t  cmd;
    frbm_stat_t stat;

    frbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_kind   (item.kind),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    frbm_dp #(
        .DIRECT_SLOTS (DIRECT_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .slot         (item.slot),
        .block_number (item.block_number),
        .file_bytes   (item.file_bytes),
        .file_mode    (item.file_mode),
        .read_offset  (item.read_offset),
        .read_count   (item.read_count),
        .status       (result.status),
        .disk_address (result.disk_address),
        .length       (result.length),
        .zero_fill    (result.zero_fill),
        .dest_offset  (result.dest_offset),
        .total_bytes  (result.total_bytes),
        .last         (result.last)
    );

endmodule

>>> bench/tb_file_read_block_mapper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_file_read_block_mapper_top
// Self-checking bench for the file read block mapper.
//
// Pointer loads and read requests go in through a queue-fed driver. Each
// accepted word runs through a local mapping of the read over the pointer
// table, which queues the chunk, done and error words it should produce. The
// monitor checks every result word field by field against that queue. Both
// channels idle in random bursts, but for the last phase. The run sweeps mount state, block size and
// disk size, the extremes among them.
// ----------------------------------------------------------------------------
module tb_file_read_block_mapper_top;
    import frbm_pkg::*;

    localparam int unsigned SLOTS     = 12;
    localparam logic        KIND_LOAD = 1'b0;
    localparam logic        KIND_READ = 1'b1;
    localparam logic [15:0] MODE_FILE = 16'h81A4;
    localparam logic [15:0] MODE_DIR  = 16'h41ED;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [31:0] block_number;
        logic [31:0] file_bytes;
        logic [15:0] file_mode;
        logic [31:0] read_offset;
        logic [31:0] read_count;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [47:0] disk_address;
        logic [16:0] length;
        logic        zero_fill;
        logic [31:0] dest_offset;
        logic [31:0] total_bytes;
        logic        last;
    } chunk_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_MOUNTED;
    logic [48:0] cfg_data  = '0;
    logic        drv_valid = 1'b0;
    req_t        drv_word  = '0;
    logic        drv_ready = 1'b0;

    frbm_in_if  item_if ();
    frbm_out_if result_if ();

    assign item_if.valid        = drv_valid;
    assign item_if.kind         = drv_word.kind;
    assign item_if.slot         = drv_word.slot;
    assign item_if.block_number = drv_word.block_number;
    assign item_if.file_bytes   = drv_word.file_bytes;
    assign item_if.file_mode    = drv_word.file_mode;
    assign item_if.read_offset  = drv_word.read_offset;
    assign item_if.read_count   = drv_word.read_count;
    assign result_if.ready      = drv_ready;

    file_read_block_mapper_top #(
        .DIRECT_SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .item     (item_if),
        .result   (result_if)
    );

    // local copy of the pointer table and registers
    logic [31:0] ptr_table [SLOTS];
    logic        fs_mounted = 1'b0;
    logic [2:0]  fs_log     = '0;
    logic [48:0] fs_disk    = '0;

    req_t   pending_requests [$];
    chunk_t expected_chunks [$];

    logic        bursts_on  = 1'b1;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned errors     = 0;
    int unsigned n_loads    = 0;
    int unsigned n_reads    = 0;
    int unsigned n_chunks   = 0;
    int unsigned n_holes    = 0;
    int unsigned n_done     = 0;
    int unsigned n_rejects  = 0;
    int unsigned n_io       = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            ptr_table[s] = '0;
        end
    end

    function automatic int unsigned block_log();
        return (fs_log > MAX_LOG) ? int'(MAX_LOG) : int'(fs_log);
    endfunction

    function automatic void emit(status_t st, logic [63:0] addr, logic [63:0] len,
                                 logic zf, logic [63:0] dst, logic [63:0] tot,
                                 logic fin);
        chunk_t c;
        c.status       = st;
        c.disk_address = addr[47:0];
        c.length       = len[16:0];
        c.zero_fill    = zf;
        c.dest_offset  = dst[31:0];
        c.total_bytes  = tot[31:0];
        c.last         = fin;
        expected_chunks.push_back(c);
    endfunction

    function automatic void map_read(req_t w);
        logic [63:0] bs, disk, off, cnt, fsize, done, pos, idx, boff, chunk, blk, addr;
        int unsigned lg;
        if (!fs_mounted)
        begin
            emit(ST_NOT_MOUNTED, 0, 0, 1'b0, 0, 0, 1'b1);
            return;
        end
        if (w.file_mode[15:12] != MODE_REGULAR)
        begin
            emit(ST_NOT_REGULAR, 0, 0, 1'b0, 0, 0, 1'b1);
            return;
        end
        fsize = 64'(w.file_bytes);
        off   = 64'(w.read_offset);
        cnt   = 64'(w.read_count);
        if (off >= fsize)
        begin
            emit(ST_DONE, 0, 0, 1'b0, 0, 0, 1'b1);
            return;
        end
        if (off + cnt > fsize)
        begin
            cnt = fsize - off;
        end
        lg   = block_log();
        bs   = 64'd1024 << lg;
        disk = (fs_disk > DISK_LIMIT) ? 64'(DISK_LIMIT) : 64'(fs_disk);
        done = 0;
        while (done < cnt)
        begin
            pos = off + done;
            idx = pos >> (BASE_LOG + lg);
            if (idx >= SLOTS)
            begin
                break;
            end
            boff  = pos & (bs - 1);
            chunk = bs - boff;
            if (chunk > cnt - done)
            begin
                chunk = cnt - done;
            end
            blk = 64'(ptr_table[idx[3:0]]);
            if (blk == 0)
            begin
                emit(ST_CHUNK, 0, chunk, 1'b1, done, done + chunk, 1'b0);
            end
            else
            begin
                addr = blk * bs;
                if (addr + bs > disk)
                begin
                    emit(ST_IO_ERROR, 0, 0, 1'b0, 0, done, 1'b1);
                    return;
                end
                emit(ST_CHUNK, addr + boff, chunk, 1'b0, done, done + chunk, 1'b0);
            end
            done += chunk;
        end
        emit(ST_DONE, 0, 0, 1'b0, 0, done, 1'b1);
    endfunction

    function automatic void take_word(req_t w);
        if (w.kind == KIND_LOAD)
        begin
            n_loads++;
            if (w.slot < SLOTS)
            begin
                ptr_table[w.slot] = w.block_number;
            end
        end
        else
        begin
            n_reads++;
            map_read(w);
        end
    endfunction

    function automatic req_t load_req(int unsigned slot, logic [31:0] blk);
        req_t w;
        w.kind         = KIND_LOAD;
        w.slot         = slot[3:0];
        w.block_number = blk;
        w.file_bytes   = $urandom;
        w.file_mode    = 16'($urandom);
        w.read_offset  = $urandom;
        w.read_count   = $urandom;
        return w;
    endfunction

    function automatic req_t read_req(logic [31:0] fsize, logic [15:0] mode,
                                      logic [31:0] off, logic [31:0] cnt);
        req_t w;
        w.kind         = KIND_READ;
        w.slot         = 4'($urandom);
        w.block_number = $urandom;
        w.file_bytes   = fsize;
        w.file_mode    = mode;
        w.read_offset  = off;
        w.read_count   = cnt;
        return w;
    endfunction

    // hole, just past the disk, last fitting block, any value, or a fitting block
    function automatic logic [31:0] pick_block();
        logic [63:0] bs, disk, nblk, top;
        bs   = 64'd1024 << block_log();
        disk = (fs_disk > DISK_LIMIT) ? 64'(DISK_LIMIT) : 64'(fs_disk);
        nblk = disk / bs;
        top  = (nblk > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nblk - 1;
        case ($urandom_range(0, 9))
            0, 1: return 32'd0;
            2: return (nblk <= 64'hFFFF_FFFF) ? nblk[31:0] : $urandom;
            3: return $urandom;
            4: return (nblk >= 2) ? top[31:0] : $urandom;
            default: return (nblk >= 2) ? $urandom_range(1, top[31:0]) : $urandom;
        endcase
    endfunction

    function automatic req_t random_read();
        logic [31:0] span, fsize, off, cnt;
        logic [15:0] mode;
        int unsigned sh;
        sh    = BASE_LOG + block_log();
        span  = 32'd12 << sh;
        mode  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : {MODE_REGULAR, 12'($urandom)};
        fsize = $urandom_range(1, span + (span >> 3));
        off   = $urandom_range(0, fsize - 1);
        cnt   = $urandom_range(1, 32'd4 << sh);
        case ($urandom_range(0, 9))
            0:
            begin
                fsize = $urandom;
                off   = $urandom;
                cnt   = $urandom;
            end
            1: off = fsize + $urandom_range(0, 2);
            2: cnt = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            3:
            begin
                off = 32'($urandom_range(0, 11)) << sh;
                cnt = span;
            end
            default: ;
        endcase
        return read_req(fsize, mode, off, cnt);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (drv_valid && item_if.ready)
            begin
                take_word(drv_word);
            end
            if (!(drv_valid && !item_if.ready))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end
                else if (bursts_on && pending_requests.size() != 0
                         && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(1, 7) - 1;
                    drv_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    drv_word  <= pending_requests.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_word();
        chunk_t want;
        if (expected_chunks.size() == 0)
        begin
            errors++;
            $display("%0t unexpected result word: expected none, actual status %0d",
                     $time, result_if.status);
            return;
        end
        want = expected_chunks.pop_front();
        check_field("status", want.status, result_if.status);
        check_field("disk_address", want.disk_address, result_if.disk_address);
        check_field("length", want.length, result_if.length);
        check_field("zero_fill", want.zero_fill, result_if.zero_fill);
        check_field("dest_offset", want.dest_offset, result_if.dest_offset);
        check_field("total_bytes", want.total_bytes, result_if.total_bytes);
        check_field("last", want.last, result_if.last);
        case (want.status)
            ST_CHUNK:
            begin
                n_chunks++;
                if (want.zero_fill)
                begin
                    n_holes++;
                end
            end
            ST_DONE:     n_done++;
            ST_IO_ERROR: n_io++;
            default:     n_rejects++;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_if.valid && drv_ready)
            begin
                check_word();
            end
            if (stall_left != 0)
            begin
                stall_left--;
                drv_ready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                drv_ready <= 1'b0;
            end
            else
            begin
                drv_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [1:0] index, logic [48:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            CFG_MOUNTED:  fs_mounted = value[0];
            CFG_LOG_SIZE: fs_log     = value[2:0];
            default:      fs_disk    = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold until every word is in and every result is out, then let loads settle
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_requests.size() != 0 || drv_valid || expected_chunks.size() != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic run_phase(logic mounted, logic [2:0] lg, logic [48:0] disk,
                             int unsigned n);
        drain();
        write_reg(CFG_MOUNTED, {48'd0, mounted});
        write_reg(CFG_LOG_SIZE, {46'd0, lg});
        write_reg(CFG_DISK, disk);
        @(negedge clk);
        for (int s = 0; s < SLOTS; s++)
        begin
            pending_requests.push_back(load_req(s, pick_block()));
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pending_requests.push_back(load_req($urandom_range(0, 15), pick_block()));
            end
            else
            begin
                pending_requests.push_back(random_read());
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers still at reset: not mounted
        pending_requests.push_back(read_req(32'd4096, MODE_FILE, 32'd0, 32'd100));
        drain();
        write_reg(CFG_MOUNTED, 49'd1);
        write_reg(CFG_LOG_SIZE, 49'd0);
        write_reg(CFG_DISK, DISK_LIMIT);
        @(negedge clk);
        pending_requests.push_back(load_req(0, 32'd5));
        pending_requests.push_back(load_req(1, 32'd0));
        pending_requests.push_back(load_req(2, 32'hFFFF_FFFF));
        pending_requests.push_back(load_req(11, 32'd7));
        pending_requests.push_back(load_req(12, 32'd3));
        pending_requests.push_back(load_req(15, 32'hFFFF_FFFF));
        pending_requests.push_back(read_req(32'd4096, MODE_DIR, 32'd0, 32'd100));
        pending_requests.push_back(read_req(32'd4096, 16'hFFFF, 32'd0, 32'd100));
        pending_requests.push_back(read_req(32'd4096, 16'h8000, 32'd4096, 32'd10));
        pending_requests.push_back(read_req(32'd4096, 16'h8FFF, 32'd5000, 32'd10));
        pending_requests.push_back(read_req(32'd0, MODE_FILE, 32'd0, 32'd10));
        pending_requests.push_back(read_req(32'd4096, MODE_FILE, 32'd10, 32'd0));
        pending_requests.push_back(read_req(32'd4096, MODE_FILE, 32'd1000, 32'd2000));
        pending_requests.push_back(read_req(32'hFFFF_FFFF, MODE_FILE, 32'd0, 32'hFFFF_FFFF));
        pending_requests.push_back(read_req(32'hFFFF_FFFF, MODE_FILE, 32'hFFFF_FFFE,
                                            32'hFFFF_FFFF));
        pending_requests.push_back(read_req(32'd12288, MODE_FILE, 32'd11265, 32'hFFFF_FFFF));

        // block 5 is the last that fits; slot 2 runs off the disk
        drain();
        write_reg(CFG_DISK, 49'd6144);
        @(negedge clk);
        pending_requests.push_back(read_req(32'd16384, MODE_FILE, 32'd0, 32'd5000));
        pending_requests.push_back(read_req(32'd100000, MODE_FILE, 32'd0, 32'd1024));

        run_phase(1'b1, 3'd0, DISK_LIMIT, 36);
        run_phase(1'b1, 3'd6, DISK_LIMIT, 36);
        run_phase(1'b1, 3'd3, 49'd1 << 24, 36);
        run_phase(1'b1, 3'd7, 49'h1_FFFF_FFFF_FFFF, 36);
        run_phase(1'b1, 3'd1, 49'd0, 24);
        run_phase(1'b1, 3'd2, {17'($urandom), 32'($urandom)}, 36);
        run_phase(1'b0, 3'd5, 49'd1 << 30, 16);
        drain();
        bursts_on = 1'b0;
        run_phase(1'b1, 3'd4, 49'd1 << 28, 40);
        drain();

        $display("covered %0d reads and %0d pointer loads over eleven register settings",
                 n_reads, n_loads);
        $display("checked %0d chunks (%0d holes), %0d done, %0d rejected, %0d io errors",
                 n_chunks, n_holes, n_done, n_rejects, n_io);
        if (errors == 0)
        begin
            $display("file_read_block_mapper_top regression: pass");
        end
        else
        begin
            $display("file_read_block_mapper_top regression: fail");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t timeout with %0d results outstanding", $time, expected_chunks.size());
        $display("file_read_block_mapper_top regression: fail");
        $finish;
    end

endmodule
